@@ hdl/edns_pkg.sv @@
// Shared types for the 3D distance block: the controller-to-datapath command
// and datapath-to-controller status structs and the axis select code.
// No dependencies.
`default_nettype none

package edns_pkg;

  // Axis select for the shared squaring multiplier
  typedef logic [1:0] axis_t;

  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic  load;      // capture the axis difference magnitudes of the input beat, clear sum
    logic  mul;       // square the selected axis magnitude
    logic  acc;       // add the last square into the sum
    logic  seed;      // start the estimate at the sum
    logic  div_init;  // start a serial division of sum by estimate
    logic  div_step;  // one quotient bit
    logic  update;    // take the Newton step if it still decreases
    logic  out_load;  // move the estimate into the output register
    axis_t axis;
  } edns_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sum_zero;
    logic converged;
  } edns_sts_t;

endpackage

`default_nettype wire

@@ hdl/euclidean_distance_newton_sqrt.sv @@
// Top level of the 3D distance block: floor Euclidean distance of two points
// by a Newton square root. Depends on edns_pkg, edns_ctrl, edns_datapath.
//
//   channel  ports                               beat
//   input    in_valid / in_ready                 in_first_x..in_second_z, signed Q16.8
//   output   out_valid / out_ready               out_span, unsigned Q.8
//
// One item at a time. An item is loaded, its three axes are squared and summed
// in turn and the estimate is seeded at the sum; each Newton iteration then runs
// the one-bit-per-cycle restoring divider over SumWidth = 2*COORD_WIDTH + 2
// quotient bits, a large sum needing about 30 iterations, and at the end the
// estimate is handed over. A zero sum skips the divider. The finished result
// waits in the output register while the next beat is taken; the block stalls
// at the end of an item only if that register is still full. Reset clears
// control only.
`default_nettype none

module euclidean_distance_newton_sqrt
  import edns_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic             [COORD_WIDTH:0]   out_span
);

  localparam int SumWidth = 2 * COORD_WIDTH + 2;

  edns_cmd_t cmd;
  edns_sts_t sts;

  edns_ctrl #(
    .SumWidth (SumWidth)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  edns_datapath #(
    .CoordWidth (COORD_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .sts      (sts),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .first_z  (in_first_z),
    .second_x (in_second_x),
    .second_y (in_second_y),
    .second_z (in_second_z),
    .span     (out_span)
  );

endmodule

`default_nettype wire

@@ hdl/edns_datapath.sv @@
// Datapath of the 3D distance block: differences, shared squarer, sum,
// restoring divider and Newton estimate, plus the output register.
// Depends on edns_pkg.
`default_nettype none

module edns_datapath
  import edns_pkg::*;
#(
  parameter int CoordWidth = 24
) (
  input  wire logic                         clk,
  input  wire edns_cmd_t                    cmd,
  output edns_sts_t                         sts,
  input  wire logic signed [CoordWidth-1:0] first_x,
  input  wire logic signed [CoordWidth-1:0] first_y,
  input  wire logic signed [CoordWidth-1:0] first_z,
  input  wire logic signed [CoordWidth-1:0] second_x,
  input  wire logic signed [CoordWidth-1:0] second_y,
  input  wire logic signed [CoordWidth-1:0] second_z,
  output logic             [CoordWidth:0]   span
);

  localparam int MagWidth = CoordWidth + 1;
  localparam int SumWidth = 2 * CoordWidth + 2;

  logic [MagWidth-1:0] mag_r [3];
  logic [MagWidth-1:0] mag_nxt [3];
  logic [SumWidth-1:0] prod_r;
  logic [SumWidth-1:0] sum_r;
  logic [SumWidth-1:0] est_r;
  logic [SumWidth-1:0] rem_r;
  logic [SumWidth-1:0] dvd_r;
  logic [CoordWidth:0] span_r;

  logic signed [MagWidth-1:0] diff [3];
  logic [MagWidth-1:0] mag_sel;
  logic [SumWidth-1:0] square;
  logic [SumWidth:0]   rem_shift;
  logic [SumWidth:0]   rem_sub;
  logic                q_bit;
  logic [SumWidth:0]   newton_sum;
  logic [SumWidth-1:0] est_nxt;

  // Per-axis differences, first minus second, and their magnitudes
  always_comb begin
    diff[0] = {first_x[CoordWidth-1], first_x} - {second_x[CoordWidth-1], second_x};
    diff[1] = {first_y[CoordWidth-1], first_y} - {second_y[CoordWidth-1], second_y};
    diff[2] = {first_z[CoordWidth-1], first_z} - {second_z[CoordWidth-1], second_z};
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = diff[i][MagWidth-1] ? MagWidth'(-diff[i]) : MagWidth'(diff[i]);
    end
  end

  // Shared squarer, one axis per command
  always_comb begin
    mag_sel = mag_r[0];
    case (cmd.axis)
      AXIS_Y:  mag_sel = mag_r[1];
      AXIS_Z:  mag_sel = mag_r[2];
      default: mag_sel = mag_r[0];
    endcase
  end

  assign square = SumWidth'(mag_sel) * SumWidth'(mag_sel);

  // Restoring division step: bring down one dividend bit, subtract if it fits
  assign rem_shift = {rem_r, dvd_r[SumWidth-1]};
  assign rem_sub   = rem_shift - {1'b0, est_r};
  assign q_bit     = (rem_shift >= {1'b0, est_r});

  // Newton step: dvd_r holds the quotient once the division is done
  assign newton_sum = {1'b0, est_r} + {1'b0, dvd_r};
  assign est_nxt    = newton_sum[SumWidth:1];

  assign sts.sum_zero  = (sum_r == '0);
  assign sts.converged = (est_nxt >= est_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= mag_nxt[i];
      end
      sum_r <= '0;
    end
    if (cmd.mul) begin
      prod_r <= square;
    end
    if (cmd.acc) begin
      sum_r <= sum_r + prod_r;
    end
    if (cmd.seed) begin
      est_r <= sum_r;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      dvd_r <= sum_r;
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? rem_sub[SumWidth-1:0] : rem_shift[SumWidth-1:0];
      dvd_r <= {dvd_r[SumWidth-2:0], q_bit};
    end
    if (cmd.update && !sts.converged) begin
      est_r <= est_nxt;
    end
    if (cmd.out_load) begin
      span_r <= est_r[CoordWidth:0];
    end
  end

  assign span = span_r;

endmodule

`default_nettype wire

@@ hdl/edns_ctrl.sv @@
// Controller of the 3D distance block: sequences squaring, seeding, the serial
// division and the Newton update, and runs both handshakes.
// Depends on edns_pkg.
`default_nettype none

module edns_ctrl
  import edns_pkg::*;
#(
  parameter int SumWidth = 50
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire edns_sts_t sts,
  output edns_cmd_t      cmd
);

  localparam int CntWidth = $clog2(SumWidth);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_SEED,
    S_DIV_INIT,
    S_DIV,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  axis_t               axis_r, axis_nxt;
  logic [CntWidth-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                in_fire;
  logic                out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.axis      = axis_r;

    // drop the result once it is taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          axis_nxt  = AXIS_X;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (axis_r == AXIS_Z) begin
          state_nxt = S_SEED;
        end else begin
          axis_nxt  = axis_r + axis_t'(1);
          state_nxt = S_MUL;
        end
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = sts.sum_zero ? S_FINISH : S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CntWidth'(1);
        if (cnt_r == CntWidth'(SumWidth - 1)) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.converged ? S_FINISH : S_DIV_INIT;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= AXIS_X;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ tb/euclidean_distance_newton_sqrt_tb.sv @@
// Self-checking testbench for euclidean_distance_newton_sqrt: floor distance
// of two Q16.8 points, predicted per beat and compared with every out_span.
// Depends on the RTL only (edns_pkg and the top level with its sub-blocks).
`timescale 1ns / 100ps

module euclidean_distance_newton_sqrt_tb;

  localparam int COORD_W       = 24;
  localparam int HOLD_CYCLES   = 6000;
  localparam int SETTLE_CYCLES = 3000;

  typedef struct {
    logic signed [COORD_W-1:0] ax, ay, az;
    logic signed [COORD_W-1:0] bx, by, bz;
  } point_pair_t;

  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_first_x  = '0;
  logic signed [COORD_W-1:0] in_first_y  = '0;
  logic signed [COORD_W-1:0] in_first_z  = '0;
  logic signed [COORD_W-1:0] in_second_x = '0;
  logic signed [COORD_W-1:0] in_second_y = '0;
  logic signed [COORD_W-1:0] in_second_z = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  logic        [COORD_W:0]   out_span;

  point_pair_t      pair_q[$];
  logic [COORD_W:0] span_q[$];
  int               err_count     = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  logic             hold_go       = 1'b0;
  logic             hold_active   = 1'b0;

  euclidean_distance_newton_sqrt #(
    .COORD_WIDTH(COORD_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_first_x (in_first_x),
    .in_first_y (in_first_y),
    .in_first_z (in_first_z),
    .in_second_x(in_second_x),
    .in_second_y(in_second_y),
    .in_second_z(in_second_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_span   (out_span)
  );

  // 2 ns clock
  always begin
    #1;
    clk = 1'b1;
    #1;
    clk = 1'b0;
  end

  // Floor square root of the summed squared differences, by the same
  // integer Newton descent: start at the sum, step while the estimate drops
  function automatic logic [COORD_W:0] calc_span(point_pair_t p);
    longint      dx, dy, dz;
    logic [63:0] sum, est, nxt;
    dx  = longint'(p.ax) - longint'(p.bx);
    dy  = longint'(p.ay) - longint'(p.by);
    dz  = longint'(p.az) - longint'(p.bz);
    sum = dx * dx + dy * dy + dz * dz;
    if (sum == 0) return '0;
    est = sum;
    nxt = (est + sum / est) >> 1;
    while (nxt < est) begin
      est = nxt;
      nxt = (est + sum / est) >> 1;
    end
    return est[COORD_W:0];
  endfunction

  task automatic flag_mismatch(string msg);
    err_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic push_pair(logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz);
    point_pair_t p;
    p.ax = ax; p.ay = ay; p.az = az;
    p.bx = bx; p.by = by; p.bz = bz;
    pair_q.push_back(p);
  endtask

  // Signed offset spread over +/- 2^(bits-1)
  function automatic logic signed [COORD_W-1:0] near_offset(int unsigned bits);
    int unsigned r;
    r = $urandom_range((32'd1 << bits) - 1);
    return COORD_W'(r) - COORD_W'(32'd1 << (bits - 1));
  endfunction

  // Mostly nearby points to keep the Newton descent short, some far apart
  task automatic push_random_pairs(int count);
    for (int i = 0; i < count; i++) begin
      point_pair_t p;
      int unsigned bits;
      p.ax = COORD_W'($urandom);
      p.ay = COORD_W'($urandom);
      p.az = COORD_W'($urandom);
      if ($urandom_range(4) == 0) begin
        p.bx = COORD_W'($urandom);
        p.by = COORD_W'($urandom);
        p.bz = COORD_W'($urandom);
      end else begin
        bits = $urandom_range(1, 14);
        p.bx = p.ax + near_offset(bits);
        p.by = p.ay + near_offset(bits);
        p.bz = p.az + near_offset(bits);
      end
      pair_q.push_back(p);
    end
  endtask

  // Hold until every queued beat is taken and every span has come back
  task automatic wait_drained();
    @(negedge clk);
    while (pair_q.size() != 0 || in_valid || span_q.size() != 0) @(negedge clk);
  endtask

  // Input driver: offer the next pending pair, idling at the current rate
  always @(posedge clk) begin : feed
    point_pair_t cur, nxt;
    logic        offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cur.ax = in_first_x;  cur.ay = in_first_y;  cur.az = in_first_z;
        cur.bx = in_second_x; cur.by = in_second_y; cur.bz = in_second_z;
        span_q.push_back(calc_span(cur));
      end
      if (!in_valid || in_ready) begin
        offer = (pair_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (offer) begin
          nxt = pair_q.pop_front();
          in_first_x  <= nxt.ax;
          in_first_y  <= nxt.ay;
          in_first_z  <= nxt.az;
          in_second_x <= nxt.bx;
          in_second_y <= nxt.by;
          in_second_z <= nxt.bz;
        end
        in_valid <= offer;
      end
    end
  end

  // Result side: stall at random, or hard during a long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_active) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long hold-off on the result side, counted here so the block fills up
  initial begin
    @(posedge hold_go);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Monitor: compare each span beat with the oldest prediction
  always @(posedge clk) begin : check
    logic [COORD_W:0] want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (span_q.size() == 0) begin
        flag_mismatch($sformatf("span %0d with nothing outstanding", out_span));
      end else begin
        want = span_q.pop_front();
        if (out_span !== want)
          flag_mismatch($sformatf("span %0d, predicted %0d", out_span, want));
      end
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sender mostly busy, receiver stalling about half the time
    send_idle_pct = 7;
    recv_idle_pct = 55;

    // Directed: zero sums, extremes, tiny and exact-square sums
    push_pair('0, '0, '0, '0, '0, '0);
    push_pair(24'sd1000, -24'sd5, C_MAX, 24'sd1000, -24'sd5, C_MAX);
    push_pair(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
    push_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    push_pair(24'sd1, '0, '0, '0, '0, '0);
    push_pair(24'sd1, 24'sd1, '0, '0, '0, '0);
    push_pair(24'sd1, 24'sd1, 24'sd1, '0, '0, '0);
    push_pair(24'sd3, 24'sd4, '0, '0, '0, '0);
    push_pair(24'sd256, '0, '0, '0, '0, '0);
    push_pair(24'sd2, 24'sd2, 24'sd4, '0, '0, '0);
    push_pair(-24'sd4, -24'sd4, -24'sd4, '0, '0, '0);
    push_pair(-24'sd1, -24'sd1, -24'sd1, C_MAX, C_MAX, C_MAX);
    push_pair('0, C_MAX, '0, '0, C_MIN, '0);
    push_pair('0, '0, C_MIN, '0, '0, C_MAX);
    push_pair(24'sh555555, 24'shAAAAAA, 24'sh555555,
              24'shAAAAAA, 24'sh555555, 24'shAAAAAA);
    push_pair(C_MIN, '0, '0, '0, '0, '0);
    push_pair(C_MAX, C_MIN, 24'sd77, C_MAX, C_MIN, -24'sd77);
    wait_drained();

    push_random_pairs(120);
    wait_drained();

    // Sender idles more than it offers; receiver quick after a long hold-off
    send_idle_pct = 55;
    recv_idle_pct = 7;
    push_random_pairs(120);
    hold_go = 1'b1;
    wait_drained();

    // Neither side idles
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_pairs(115);
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit, well beyond the slowest correct run
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/edns_pkg.sv
hdl/edns_datapath.sv
hdl/edns_ctrl.sv
hdl/euclidean_distance_newton_sqrt.sv
tb/euclidean_distance_newton_sqrt_tb.sv
